// ----- hdl/tpq_pkg.sv -----
package tpq_pkg;

  // result kinds carried on the master-side tuser
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_REPORT  = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;
  localparam logic [1:0] EV_REJECT  = 2'd3;

  // register indexes, address bits [3:2]
  localparam logic [1:0] REG_PLATE_OHMS    = 2'd0;
  localparam logic [1:0] REG_RT_CEILING    = 2'd1;
  localparam logic [1:0] REG_RT_FLOOR      = 2'd2;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

  // reset values of the registers
  localparam logic [15:0] PLATE_OHMS_RST    = 16'd400;
  localparam logic [15:0] RT_CEILING_RST    = 16'd65535;
  localparam logic [15:0] RT_FLOOR_RST      = 16'd65535;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd48;

endpackage

// ----- hdl/touch_pressure_qualifier.sv -----
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: x, y, z1, z2; tuser: mode (1 = tick)
// m_*       out  m_tvalid/m_tready  tdata: x, y, pressure, touching; tuser: kind
// apb       in   psel/penable       four 16-bit registers at 0x0, 0x4, 0x8, 0xC
//
// A tick or a sample failing the x, z1 or z2 checks skips the arithmetic and goes straight
// to the write step; a qualified sample passes two multiply steps, one restoring-divider
// step per bit of the 2*SAMPLE_BITS+16 bit product, rounding and write. s_tready is high
// only while idle, so the block takes no new item before it is through with the last one.
// Reset (rst, synchronous) restores the register defaults, stops the pen-up timer and
// clears the stored point. A stalled output holds the write step.
module touch_pressure_qualifier
  import tpq_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                      clk,
  input  logic                                      rst,
  // input stream
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // tdata: x_sample, y_sample, z1_sample, z2_sample, zero fill
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
  // tuser: mode
  input  logic                                      s_tuser,
  // result stream
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // tdata: report_x, report_y, report_pressure, touching, zero fill
  output logic [((2*SAMPLE_BITS+17+7)/8)*8-1:0]     m_tdata,
  // tuser: event_kind
  output logic [1:0]                                m_tuser,
  // configuration port
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [3:0]                                paddr,
  input  logic [31:0]                               pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);

  localparam int SB     = SAMPLE_BITS;
  localparam int PROD_W = 2*SB + 16;                 // (z2-z1) * x * plate_ohms
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int RT_W   = PROD_W + 1 - SB;           // rounded, shifted quotient
  localparam int OUT_W  = ((2*SB+17+7)/8)*8;
  localparam logic [PROD_W:0] HALF = (PROD_W+1)'((1 << (SB-1)) - 1);
  localparam logic [SB-1:0]   SAMPLE_MAX = {SB{1'b1}};

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL1  = 3'd1;
  localparam logic [2:0] ST_MUL2  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;

  logic [2:0] state;

  // configuration registers
  logic [15:0] plate_ohms;
  logic [15:0] rt_ceiling;
  logic [15:0] rt_floor;
  logic [15:0] timeout_ticks;

  // pen state
  logic [SB-1:0] last_x;
  logic [SB-1:0] last_y;
  logic [15:0]   last_pressure;
  logic [15:0]   pen_timer;

  // item being worked on
  logic          item_tick;
  logic [SB-1:0] item_x;
  logic [SB-1:0] item_y;
  logic [SB-1:0] item_z1;
  logic [SB-1:0] item_z2;
  logic          rej;
  logic [15:0]   rt;

  // multiply and divide datapath
  logic [2*SB-1:0]  p1;
  logic [PROD_W-1:0] quo;     // dividend shifts out, quotient shifts in
  logic [SB-1:0]    rem;
  logic [CNT_W-1:0] cnt;

  logic [SB-1:0] in_x, in_y, in_z1, in_z2;
  logic          in_bad;
  logic [SB:0]   trial;
  logic          ge;
  logic [SB:0]   trial_sub;
  logic [PROD_W:0] rt_sum;
  logic [RT_W-1:0] rt_full;
  logic          rt_ok;

  logic          out_free;
  logic [1:0]    kind_next;
  logic [15:0]   timer_next;
  logic [OUT_W-1:0] data_next;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  assign in_x  = s_tdata[SB-1:0];
  assign in_y  = s_tdata[2*SB-1:SB];
  assign in_z1 = s_tdata[3*SB-1:2*SB];
  assign in_z2 = s_tdata[4*SB-1:3*SB];
  assign in_bad = (in_x == '0) || (in_z1 == '0) || (in_z2 < in_z1);

  // shared restoring subtractor: one quotient bit per cycle
  assign trial     = {rem, quo[PROD_W-1]};
  assign ge        = (trial >= {1'b0, item_z1});
  assign trial_sub = trial - {1'b0, item_z1};

  assign rt_sum  = {1'b0, quo} + HALF;
  assign rt_full = rt_sum[PROD_W:SB];
  assign rt_ok   = (rt_full <= RT_W'(rt_ceiling)) && (rt_full >= RT_W'(rt_floor));

  // read back
  always_comb begin
    unique case (paddr[3:2])
      REG_PLATE_OHMS:    prdata = {16'd0, plate_ohms};
      REG_RT_CEILING:    prdata = {16'd0, rt_ceiling};
      REG_RT_FLOOR:      prdata = {16'd0, rt_floor};
      REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks};
      default:           prdata = '0;
    endcase
  end

  // result and timer update for the write step
  always_comb begin
    kind_next  = EV_NONE;
    timer_next = pen_timer;
    data_next  = '0;
    if (item_tick) begin
      if (pen_timer != 16'd0) begin
        timer_next = pen_timer - 16'd1;
        if (pen_timer == 16'd1) begin
          kind_next = EV_RELEASE;
        end
      end
    end else begin
      timer_next = timeout_ticks;
      if (rej) begin
        kind_next = EV_REJECT;
      end else if (pen_timer != 16'd0) begin
        // report the point stored by the previous qualified sample
        kind_next = EV_REPORT;
        data_next[SB-1:0]         = last_x;
        data_next[2*SB-1:SB]      = SAMPLE_MAX - last_y;
        data_next[2*SB+15:2*SB]   = last_pressure;
        data_next[2*SB+16]        = 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      plate_ohms    <= PLATE_OHMS_RST;
      rt_ceiling    <= RT_CEILING_RST;
      rt_floor      <= RT_FLOOR_RST;
      timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PLATE_OHMS:    plate_ohms    <= pwdata[15:0];
        REG_RT_CEILING:    rt_ceiling    <= pwdata[15:0];
        REG_RT_FLOOR:      rt_floor      <= pwdata[15:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      pen_timer     <= 16'd0;
      last_x        <= '0;
      last_y        <= '0;
      last_pressure <= 16'd0;
    end else begin
      // the write step sets its own valid
      if (m_tvalid && m_tready && state != ST_WRITE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            // tick or failed sanity checks skip the arithmetic
            state <= (s_tuser || in_bad) ? ST_WRITE : ST_MUL1;
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_DIV;
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: state <= ST_WRITE;
        ST_WRITE: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            pen_timer <= timer_next;
            if (!item_tick && !rej) begin
              last_x        <= item_x;
              last_y        <= item_y;
              last_pressure <= rt;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      item_tick <= s_tuser;
      item_x    <= in_x;
      item_y    <= in_y;
      item_z1   <= in_z1;
      item_z2   <= in_z2;
      rej       <= in_bad;
    end
    if (state == ST_MUL1) begin
      p1 <= (2*SB)'(item_z2 - item_z1) * (2*SB)'(item_x);
    end
    if (state == ST_MUL2) begin
      quo <= PROD_W'(p1) * PROD_W'(plate_ohms);
      rem <= '0;
      cnt <= CNT_W'(PROD_W - 1);
    end
    if (state == ST_DIV) begin
      rem <= ge ? trial_sub[SB-1:0] : trial[SB-1:0];
      quo <= {quo[PROD_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
    end
    if (state == ST_FIN) begin
      rt  <= rt_full[15:0];
      rej <= !rt_ok;
    end
    if (state == ST_WRITE && out_free) begin
      m_tuser <= kind_next;
      m_tdata <= data_next;
    end
  end

endmodule

// ----- hdl/tpq_checker.sv -----
module tpq_checker
  import tpq_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic [((4*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  input logic                                  s_tuser,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((2*SAMPLE_BITS+17+7)/8)*8-1:0] m_tdata,
  input logic [1:0]                            m_tuser,
  input logic                                  psel,
  input logic                                  penable,
  input logic                                  pwrite,
  input logic [3:0]                            paddr,
  input logic [31:0]                           pwdata,
  input logic [31:0]                           prdata,
  input logic                                  pready
);

  localparam int TOUCH_POS = 2*SAMPLE_BITS + 16;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // one item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // only a touch report carries a payload
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != EV_REPORT |-> m_tdata == '0)
    else $error("payload on a non-report result");

  // a touch report always shows the button pressed
  a_report_touch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_REPORT |-> m_tdata[TOUCH_POS])
    else $error("report without touching");

endmodule

bind touch_pressure_qualifier tpq_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tpq_checker (.*);

// ----- tb/tb_touch_pressure_qualifier.sv -----
`timescale 1ns / 1ps

module tb_touch_pressure_qualifier;
  import tpq_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam int S_DATA_W = ((4*SAMPLE_BITS+7)/8)*8;
  localparam int M_DATA_W = ((2*SAMPLE_BITS+17+7)/8)*8;
  localparam logic [11:0] SAMPLE_MAX = 12'hFFF;
  // rounding term added before the final shift: 2^(SAMPLE_BITS-1) - 1
  localparam longint unsigned RT_ROUND = (64'd1 << (SAMPLE_BITS-1)) - 1;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 50;
  // allow for the arithmetic of qualified samples, sender gaps, receiver
  // stalls, the long hold-off and the register traffic, then several times more
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS = 40;

  // one result of the block, fields in the order of m_tdata / m_tuser
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] rx;
    logic [11:0] ry;
    logic [15:0] rp;
    logic        touch;
  } touch_event_t;

  // one row of the directed table: a register write or an input item
  typedef struct {
    bit           is_cfg;
    logic [1:0]   reg_idx;
    logic [15:0]  value;
    logic         mode;
    logic [11:0]  x, y, z1, z2;
    bit           known;
    touch_event_t want;
  } step_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;  // x_sample, y_sample, z1_sample, z2_sample, zero fill
  logic                s_tuser;  // mode (1 = tick)
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;  // report_x, report_y, report_pressure, touching, zero fill
  logic [1:0]          m_tuser;  // event_kind
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [3:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  touch_pressure_qualifier #(.SAMPLE_BITS(SAMPLE_BITS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the registers and of the pen state
  logic [15:0] cfg_plate_ohms, cfg_rt_ceiling, cfg_rt_floor, cfg_timeout;
  logic [11:0] pen_x, pen_y;
  logic [15:0] pen_pressure;
  logic [15:0] pen_countdown;

  touch_event_t pending_events[$];
  step_t        directed_steps[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  results_seen = 0;
  int  samples_sent = 0;
  int  ticks_sent = 0;
  int  reg_writes = 0;
  int  kinds_seen[4] = '{0, 0, 0, 0};
  bit  calm = 0;
  bit  hold_done = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // give up on a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_events.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_err(input string msg);
    if (error_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic touch_event_t mk_event(input logic [1:0] kind, input logic [11:0] rx,
                                            input logic [11:0] ry, input logic [15:0] rp,
                                            input logic touch);
    touch_event_t e;
    e.kind = kind; e.rx = rx; e.ry = ry; e.rp = rp; e.touch = touch;
    return e;
  endfunction

  function automatic step_t cfg_step(input logic [1:0] idx, input logic [15:0] v);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1; s.reg_idx = idx; s.value = v;
    return s;
  endfunction

  function automatic step_t item_step(input logic mode, input logic [11:0] x, y, z1, z2,
                                      input bit known, input touch_event_t want);
    step_t s;
    s = '{default: '0};
    s.mode = mode; s.x = x; s.y = y; s.z1 = z1; s.z2 = z2;
    s.known = known; s.want = want;
    return s;
  endfunction

  // Advance the shadow pen state by one item and return the result it causes.
  function automatic touch_event_t predict_touch_event(input logic mode,
                                                       input logic [11:0] x, y, z1, z2);
    touch_event_t    res;
    bit              running;
    bit              ok;
    longint unsigned dz, lx, lz1, lplate, rt;
    res = mk_event(EV_NONE, '0, '0, '0, 1'b0);
    if (mode) begin
      // tick: count down a running timer, release on reaching zero
      if (pen_countdown != 0) begin
        pen_countdown = pen_countdown - 16'd1;
        if (pen_countdown == 0) res.kind = EV_RELEASE;
      end
      return res;
    end
    running = (pen_countdown != 0);
    pen_countdown = cfg_timeout;
    ok = (x != 0) && (z1 != 0) && (z2 >= z1);
    if (ok) begin
      dz = z2;
      dz = dz - z1;
      lx = x;
      lz1 = z1;
      lplate = cfg_plate_ohms;
      rt = ((dz * lx * lplate) / lz1 + RT_ROUND) >> SAMPLE_BITS;
      ok = (rt <= cfg_rt_ceiling) && (rt >= cfg_rt_floor);
    end
    if (!ok) begin
      res.kind = EV_REJECT;
      return res;
    end
    if (running) res = mk_event(EV_REPORT, pen_x, SAMPLE_MAX - pen_y, pen_pressure, 1'b1);
    pen_x = x;
    pen_y = y;
    pen_pressure = rt[15:0];
    return res;
  endfunction

  // mostly short gaps, a few long ones, none at all in a calm phase
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item after a random gap, hold it until the transfer, then
  // queue what it should produce.
  task automatic send_item(input logic mode, input logic [11:0] x, y, z1, z2,
                           input bit known, input touch_event_t want);
    int           gap;
    touch_event_t pred;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {z2, z1, y, x};
    do @(posedge clk); while (!s_tready);
    pred = predict_touch_event(mode, x, y, z1, z2);
    pending_events.push_back(known ? want : pred);
    if (mode) ticks_sent++;
    else samples_sent++;
  endtask

  // Drop the input, let every owed result drain, and give the block a few
  // spare cycles before touching a register.
  task automatic settle_block();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write, then read it back.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {16'd0, v};
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PLATE_OHMS:    cfg_plate_ohms = v;
      REG_RT_CEILING:    cfg_rt_ceiling = v;
      REG_RT_FLOOR:      cfg_rt_floor = v;
      REG_TIMEOUT_TICKS: cfg_timeout = v;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== v)
      report_err($sformatf("register %0d read back %h, wrote %h", idx, prdata[15:0], v));
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // Pick one random setting; most keep a wide acceptance window and a short
  // pen-up timeout so that reports and releases both show up.
  task automatic random_config();
    logic [15:0] plate, pmin, pmax, tmo;
    case ($urandom_range(0, 5))
      0: plate = 16'd0;
      1: plate = 16'hFFFF;
      default: plate = 16'($urandom_range(1, 2000));
    endcase
    case ($urandom_range(0, 9))
      0: pmin = 16'hFFFF;
      1, 2: pmin = 16'd0;
      default: pmin = 16'($urandom_range(0, 400));
    endcase
    case ($urandom_range(0, 9))
      0: pmax = 16'd0;
      1, 2: pmax = 16'hFFFF;
      default: pmax = 16'($urandom_range(int'(pmin), 65535));
    endcase
    case ($urandom_range(0, 9))
      0: tmo = 16'd0;
      1: tmo = 16'hFFFF;
      default: tmo = 16'($urandom_range(1, 6));
    endcase
    write_reg(REG_PLATE_OHMS, plate);
    write_reg(REG_RT_CEILING, pmax);
    write_reg(REG_RT_FLOOR, pmin);
    write_reg(REG_TIMEOUT_TICKS, tmo);
  endtask

  // One random item: ticks, well-formed samples, raw noise, or a sample that
  // breaks one of the x, z1, z2 checks.
  task automatic random_item();
    int          r;
    logic [11:0] x, y, z1, z2;
    r = $urandom_range(0, 99);
    x  = 12'($urandom());
    y  = 12'($urandom());
    z1 = 12'($urandom());
    z2 = 12'($urandom());
    if (r < 35) begin
      send_item(1'b1, x, y, z1, z2, 1'b0, '0);
      return;
    end
    if (r < 85) begin
      x  = 12'($urandom_range(1, 4095));
      z1 = 12'($urandom_range(1, 4095));
      z2 = 12'($urandom_range(int'(z1), 4095));
    end else if (r >= 95) begin
      case ($urandom_range(0, 2))
        0: x = 12'd0;
        1: z1 = 12'd0;
        default: begin
          z1 = 12'($urandom_range(1, 4095));
          z2 = 12'($urandom_range(0, int'(z1) - 1));
        end
      endcase
    end
    send_item(1'b0, x, y, z1, z2, 1'b0, '0);
  endtask

  // Result side: random ready pattern plus one long hold-off once traffic is
  // flowing, so the block fills up and pushes back on its input.
  initial begin
    int gap;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = idle_len();
      if (gap == 0) begin
        m_tready <= 1'b1;
        @(negedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Compare every result transfer with the oldest owed result.
  always @(posedge clk) begin : result_check
    touch_event_t want;
    touch_event_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = mk_event(m_tuser, m_tdata[11:0], m_tdata[23:12], m_tdata[39:24], m_tdata[40]);
      results_seen++;
      kinds_seen[got.kind]++;
      if (pending_events.size() == 0) begin
        report_err($sformatf("unexpected result kind %0d", got.kind));
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind)
          report_err($sformatf("result %0d kind %0d, want %0d", results_seen, got.kind,
                               want.kind));
        if (got.rx !== want.rx)
          report_err($sformatf("result %0d x %0d, want %0d", results_seen, got.rx, want.rx));
        if (got.ry !== want.ry)
          report_err($sformatf("result %0d y %0d, want %0d", results_seen, got.ry, want.ry));
        if (got.rp !== want.rp)
          report_err($sformatf("result %0d pressure %0d, want %0d", results_seen, got.rp,
                               want.rp));
        if (got.touch !== want.touch)
          report_err($sformatf("result %0d touching %0b, want %0b", results_seen, got.touch,
                               want.touch));
      end
    end
  end

  initial begin
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    rst = 1'b1;
    cfg_plate_ohms = PLATE_OHMS_RST;
    cfg_rt_ceiling = RT_CEILING_RST;
    cfg_rt_floor = RT_FLOOR_RST;
    cfg_timeout = TIMEOUT_TICKS_RST;
    pen_x = '0; pen_y = '0; pen_pressure = '0; pen_countdown = '0;

    // Directed table. Reset defaults reject everything below 65535 ohms.
    // tick with the timer stopped after reset
    directed_steps.push_back(item_step(1, 12'd0, 12'd0, 12'd0, 12'd0, 1,
                                       mk_event(EV_NONE, 0, 0, 0, 0)));
    // zero x
    directed_steps.push_back(item_step(0, 12'd0, 12'd123, 12'd100, 12'd200, 1,
                                       mk_event(EV_REJECT, 0, 0, 0, 0)));
    // zero z1
    directed_steps.push_back(item_step(0, 12'd100, 12'd7, 12'd0, 12'd200, 1,
                                       mk_event(EV_REJECT, 0, 0, 0, 0)));
    // z2 below z1
    directed_steps.push_back(item_step(0, 12'd100, 12'd7, 12'd200, 12'd100, 1,
                                       mk_event(EV_REJECT, 0, 0, 0, 0)));
    // well-formed but under the default minimum
    directed_steps.push_back(item_step(0, 12'd100, 12'd5, 12'd100, 12'd200, 1,
                                       mk_event(EV_REJECT, 0, 0, 0, 0)));
    // resistance far beyond 16 bits
    directed_steps.push_back(item_step(0, 12'hFFF, 12'hFFF, 12'd1, 12'hFFF, 1,
                                       mk_event(EV_REJECT, 0, 0, 0, 0)));
    // open the window, three-tick timeout
    directed_steps.push_back(cfg_step(REG_RT_FLOOR, 16'd0));
    directed_steps.push_back(cfg_step(REG_RT_CEILING, 16'hFFFF));
    directed_steps.push_back(cfg_step(REG_PLATE_OHMS, 16'd400));
    directed_steps.push_back(cfg_step(REG_TIMEOUT_TICKS, 16'd3));
    // timer still running from the rejects: report the cleared stored point
    directed_steps.push_back(item_step(0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1,
                                       mk_event(EV_REPORT, 0, 12'hFFF, 0, 1)));
    directed_steps.push_back(item_step(0, 12'd1, 12'd0, 12'd1, 12'hFFF, 0, '0));
    directed_steps.push_back(item_step(1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 0, '0));
    directed_steps.push_back(item_step(1, 12'd0, 12'd0, 12'd0, 12'd0, 0, '0));
    // third tick of three: release
    directed_steps.push_back(item_step(1, 12'd0, 12'd0, 12'd0, 12'd0, 1,
                                       mk_event(EV_RELEASE, 0, 0, 0, 0)));
    directed_steps.push_back(item_step(1, 12'd0, 12'd0, 12'd0, 12'd0, 1,
                                       mk_event(EV_NONE, 0, 0, 0, 0)));
    // accepted with the timer stopped: stored, nothing reported
    directed_steps.push_back(item_step(0, 12'd2048, 12'd2048, 12'd2048, 12'd3000, 0, '0));
    // narrow window, largest plate, one-tick timeout
    directed_steps.push_back(cfg_step(REG_PLATE_OHMS, 16'hFFFF));
    directed_steps.push_back(cfg_step(REG_RT_CEILING, 16'd100));
    directed_steps.push_back(cfg_step(REG_RT_FLOOR, 16'd50));
    directed_steps.push_back(cfg_step(REG_TIMEOUT_TICKS, 16'd1));
    directed_steps.push_back(item_step(0, 12'hFFF, 12'd9, 12'hFFF, 12'hFFF, 1,
                                       mk_event(EV_REJECT, 0, 0, 0, 0)));
    directed_steps.push_back(item_step(0, 12'd5, 12'd77, 12'd1, 12'd2, 0, '0));
    directed_steps.push_back(item_step(1, 12'd0, 12'd0, 12'd0, 12'd0, 0, '0));
    // zero plate, zero timeout: samples never start the timer
    directed_steps.push_back(cfg_step(REG_PLATE_OHMS, 16'd0));
    directed_steps.push_back(cfg_step(REG_RT_FLOOR, 16'd0));
    directed_steps.push_back(cfg_step(REG_TIMEOUT_TICKS, 16'd0));
    directed_steps.push_back(item_step(0, 12'd300, 12'd400, 12'd10, 12'd20, 1,
                                       mk_event(EV_NONE, 0, 0, 0, 0)));
    directed_steps.push_back(item_step(0, 12'd301, 12'd401, 12'd11, 12'd21, 1,
                                       mk_event(EV_NONE, 0, 0, 0, 0)));
    directed_steps.push_back(item_step(1, 12'd0, 12'd0, 12'd0, 12'd0, 1,
                                       mk_event(EV_NONE, 0, 0, 0, 0)));
    // longest timeout
    directed_steps.push_back(cfg_step(REG_PLATE_OHMS, 16'hFFFF));
    directed_steps.push_back(cfg_step(REG_RT_CEILING, 16'hFFFF));
    directed_steps.push_back(cfg_step(REG_TIMEOUT_TICKS, 16'hFFFF));
    directed_steps.push_back(item_step(0, 12'hFFF, 12'd1, 12'hFFF, 12'hFFF, 0, '0));
    directed_steps.push_back(item_step(1, 12'd0, 12'd0, 12'd0, 12'd0, 0, '0));

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // walk the directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        settle_block();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].value);
      end else begin
        send_item(directed_steps[i].mode, directed_steps[i].x, directed_steps[i].y,
                  directed_steps[i].z1, directed_steps[i].z2, directed_steps[i].known,
                  directed_steps[i].want);
      end
    end

    // random phases, each under a fresh setting; some run without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_block();
      random_config();
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) random_item();
    end

    // drain, then watch a while for stray results
    calm = 1'b0;
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d samples and %0d ticks over %0d register writes",
             samples_sent, ticks_sent, reg_writes);
    $display("results: %0d none, %0d reports, %0d releases, %0d rejects",
             kinds_seen[EV_NONE], kinds_seen[EV_REPORT], kinds_seen[EV_RELEASE],
             kinds_seen[EV_REJECT]);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
